/* src/deadline_task_release_queue_top_macros.svh */
// Assertion macros used by the checker file of the release queue.
`ifndef DEADLINE_TASK_RELEASE_QUEUE_TOP_MACROS_SVH
`define DEADLINE_TASK_RELEASE_QUEUE_TOP_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, held off during reset.
`define DTRQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Implication form: the antecedent at one edge implies the consequent.
`define DTRQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  `DTRQ_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

`endif

/* src/dtrq_pkg.sv */
// ----------------------------------------------------------------------------
// dtrq_pkg
// Constants, codes and controller/datapath interface types of the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtrq_pkg;

  localparam int TIMER_DEPTH = 16;
  localparam int TASK_COUNT  = 16;
  localparam int TICK_BITS   = 16;

  localparam int TIMER_IDX_W = $clog2(TIMER_DEPTH);
  localparam int TIMER_CNT_W = $clog2(TIMER_DEPTH + 1);
  localparam int READY_IDX_W = $clog2(TASK_COUNT);
  localparam int READY_CNT_W = $clog2(TASK_COUNT + 1);

  localparam int ID_W    = 4;
  localparam int DELAY_W = 16;
  localparam int REL_W   = 5;

  localparam logic [REL_W-1:0] REL_MAX = '1;

  localparam logic [1:0] OP_NOW   = 2'd0;
  localparam logic [1:0] OP_DELAY = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_TAKE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_step;
    logic move;
    logic load_out;
  } dtrq_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       scan_done;
    logic       found;
    logic       ready_full;
    logic       out_free;
  } dtrq_stat_t;

endpackage

/* src/dtrq_ctrl.sv */
// ----------------------------------------------------------------------------
// dtrq_ctrl
// Sequencer: accepts a request, runs it, scans and releases on a tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtrq_ctrl import dtrq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dtrq_stat_t stat_i,
  output dtrq_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_SCAN = 5'b00100,
    S_MOVE = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = (stat_i.op == OP_TICK) ? S_SCAN : S_FIN;
      end
      S_SCAN: begin
        // A due entry is released only while the ready queue has room.
        if (!stat_i.scan_done) begin
          cmd_o.scan_step = 1'b1;
        end else if (stat_i.found && !stat_i.ready_full) begin
          state_d = S_MOVE;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = S_SCAN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* src/dtrq_dp.sv */
// ----------------------------------------------------------------------------
// dtrq_dp
// Datapath: tick counter, timer queue, ready FIFO, scan unit, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtrq_dp import dtrq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         opcode_i,
  input  logic [ID_W-1:0]    task_id_i,
  input  logic [DELAY_W-1:0] delay_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ID_W-1:0]    popped_task_o,
  output logic [1:0]         status_o,
  output logic [REL_W-1:0]   released_o,
  input  dtrq_cmd_t          cmd_i,
  output dtrq_stat_t         stat_o
);

  logic [1:0]             op_q;
  logic [ID_W-1:0]        id_q;
  logic [DELAY_W-1:0]     delay_q;

  logic [TICK_BITS-1:0]   tick_q;
  logic [TICK_BITS-1:0]   tq_dl_q [TIMER_DEPTH];
  logic [ID_W-1:0]        tq_id_q [TIMER_DEPTH];
  logic [TIMER_CNT_W-1:0] tq_cnt_q;

  logic [ID_W-1:0]        rf_q [TASK_COUNT];
  logic [READY_IDX_W-1:0] rf_head_q, rf_tail_q;
  logic [READY_CNT_W-1:0] rf_cnt_q;

  logic [TIMER_CNT_W-1:0] scan_idx_q;
  logic                   best_found_q;
  logic [TIMER_IDX_W-1:0] best_idx_q;
  logic [TICK_BITS-1:0]   best_age_q;
  logic [ID_W-1:0]        best_id_q;
  logic [REL_W-1:0]       rel_q;

  logic [ID_W-1:0]        res_task_q;
  logic [1:0]             res_status_q;
  logic                   out_valid_q;
  logic [ID_W-1:0]        out_task_q;
  logic [1:0]             out_status_q;
  logic [REL_W-1:0]       out_rel_q;

  logic [TIMER_IDX_W-1:0] rd_idx;
  logic [TICK_BITS-1:0]   age;
  logic                   better;
  logic                   tq_full, rf_full, rf_empty;
  logic                   push_now, push_move, pop, append;
  logic [ID_W-1:0]        push_id;
  logic [READY_IDX_W-1:0] head_nxt, tail_nxt;

  assign rd_idx = scan_idx_q[TIMER_IDX_W-1:0];
  assign age    = tick_q - tq_dl_q[rd_idx];
  // Due means the modular age is nonzero and in the lower half of the range.
  assign better = (age != '0) && !age[TICK_BITS-1] && (!best_found_q || age > best_age_q);

  assign tq_full  = (tq_cnt_q == TIMER_CNT_W'(TIMER_DEPTH));
  assign rf_full  = (rf_cnt_q == READY_CNT_W'(TASK_COUNT));
  assign rf_empty = (rf_cnt_q == '0);

  assign push_now  = cmd_i.exec && (op_q == OP_NOW) && !rf_full;
  assign push_move = cmd_i.move;
  assign pop       = cmd_i.exec && (op_q == OP_TAKE) && !rf_empty;
  assign append    = cmd_i.exec && (op_q == OP_DELAY) && !tq_full;
  assign push_id   = push_move ? best_id_q : id_q;

  assign head_nxt = (rf_head_q == READY_IDX_W'(TASK_COUNT - 1)) ? '0 : rf_head_q + 1'b1;
  assign tail_nxt = (rf_tail_q == READY_IDX_W'(TASK_COUNT - 1)) ? '0 : rf_tail_q + 1'b1;

  // Request capture and queue storage; payload only, no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= opcode_i;
      id_q    <= task_id_i;
      delay_q <= delay_i;
    end
    if (push_now || push_move) begin
      rf_q[rf_tail_q] <= push_id;
    end
    if (append) begin
      tq_dl_q[tq_cnt_q[TIMER_IDX_W-1:0]] <= tick_q + TICK_BITS'(delay_q);
      tq_id_q[tq_cnt_q[TIMER_IDX_W-1:0]] <= id_q;
    end
    // Removal closes the gap so that insertion order survives.
    if (cmd_i.move) begin
      for (int i = 0; i < TIMER_DEPTH - 1; i++) begin
        if (TIMER_IDX_W'(i) >= best_idx_q) begin
          tq_dl_q[i] <= tq_dl_q[i+1];
          tq_id_q[i] <= tq_id_q[i+1];
        end
      end
    end
    if (cmd_i.scan_step && better) begin
      best_idx_q <= rd_idx;
      best_age_q <= age;
      best_id_q  <= tq_id_q[rd_idx];
    end
    if (cmd_i.exec) begin
      res_task_q <= pop ? rf_q[rf_head_q] : '0;
      priority if ((op_q == OP_NOW && rf_full) || (op_q == OP_DELAY && tq_full)) begin
        res_status_q <= ST_FULL;
      end else if (op_q == OP_TAKE && rf_empty) begin
        res_status_q <= ST_EMPTY;
      end else begin
        res_status_q <= ST_OK;
      end
    end
    if (cmd_i.load_out) begin
      out_task_q   <= res_task_q;
      out_status_q <= res_status_q;
      out_rel_q    <= rel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       <= '0;
      tq_cnt_q     <= '0;
      rf_head_q    <= '0;
      rf_tail_q    <= '0;
      rf_cnt_q     <= '0;
      scan_idx_q   <= '0;
      best_found_q <= 1'b0;
      rel_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        rel_q        <= '0;
        scan_idx_q   <= '0;
        best_found_q <= 1'b0;
        if (op_q == OP_TICK) begin
          tick_q <= tick_q + 1'b1;
        end
      end
      if (append) begin
        tq_cnt_q <= tq_cnt_q + 1'b1;
      end
      if (cmd_i.scan_step) begin
        scan_idx_q <= scan_idx_q + 1'b1;
        if (better) begin
          best_found_q <= 1'b1;
        end
      end
      if (cmd_i.move) begin
        tq_cnt_q     <= tq_cnt_q - 1'b1;
        scan_idx_q   <= '0;
        best_found_q <= 1'b0;
        if (rel_q != REL_MAX) begin
          rel_q <= rel_q + 1'b1;
        end
      end
      if (push_now || push_move) begin
        rf_tail_q <= tail_nxt;
        rf_cnt_q  <= rf_cnt_q + 1'b1;
      end
      if (pop) begin
        rf_head_q <= head_nxt;
        rf_cnt_q  <= rf_cnt_q - 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.op         = op_q;
  assign stat_o.scan_done  = (scan_idx_q == tq_cnt_q);
  assign stat_o.found      = best_found_q;
  assign stat_o.ready_full = rf_full;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign popped_task_o = out_task_q;
  assign status_o      = out_status_q;
  assign released_o    = out_rel_q;

endmodule

/* src/deadline_task_release_queue_top.sv */
// ----------------------------------------------------------------------------
// deadline_task_release_queue_top
// Tick-driven timer queue that releases due task ids into a FIFO ready queue.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | opcode, task_id, delay
//  out     | output    | out_valid/out_stall | popped_task, status, released
//
// Schedule and take requests pass through accept, execute and load of the
// result; the load waits while a stalled result still holds the output.
// A tick scans the timer queue one entry a cycle and releases the oldest due
// entry after each full scan, until none is due or the ready queue is full.
// Reset empties both queues and clears the tick counter; no clearing pass.
// One request is worked on at a time; a result stalled at the output holds the
// next result back, while the next request may already be accepted.
`timescale 1ns / 1ps

module deadline_task_release_queue_top import dtrq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic [ID_W-1:0]    task_id_i,
  input  logic [DELAY_W-1:0] delay_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ID_W-1:0]    popped_task_o,
  output logic [1:0]         status_o,
  output logic [REL_W-1:0]   released_o
);

  dtrq_cmd_t  cmd;
  dtrq_stat_t stat;

  dtrq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dtrq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (opcode_i),
    .task_id_i     (task_id_i),
    .delay_i       (delay_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .popped_task_o (popped_task_o),
    .status_o      (status_o),
    .released_o    (released_o),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

/* src/dtrq_checker.sv */
// ----------------------------------------------------------------------------
// dtrq_checker
// Port-level checks of the release queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "deadline_task_release_queue_top_macros.svh"

module dtrq_checker import dtrq_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [ID_W-1:0]    popped_task_o,
  input logic [1:0]         status_o,
  input logic [REL_W-1:0]   released_o
);

  // Requests are taken one at a time, so acceptance closes the input.
  `DTRQ_ASSERT_IMP(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o, ##1 in_stall_o)
  // A failed request never carries a task id or a release count.
  `DTRQ_ASSERT_IMP(a_fail_no_data, clk_i, rst_ni, out_valid_o && status_o != ST_OK,
                   popped_task_o == '0 && released_o == '0)
  // A popped id and a release count never come in the same result.
  `DTRQ_ASSERT_IMP(a_pop_or_tick, clk_i, rst_ni, out_valid_o && released_o != '0,
                   popped_task_o == '0)
  `DTRQ_ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   ##1 (out_valid_o && $stable(status_o) && $stable(popped_task_o)))

endmodule

bind deadline_task_release_queue_top dtrq_checker u_dtrq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .popped_task_o (popped_task_o),
  .status_o      (status_o),
  .released_o    (released_o)
);
